[rtl/core/ghcm_pkg.sv]
// shared types and constants of the grid hit count map
package ghcm_pkg;

	localparam int GRID_COLS_DEF = 1024;
	localparam int GRID_ROWS_DEF = 1024;
	localparam int QUEUE_DEPTH   = 4;

	localparam int POS_W     = 32;
	localparam int CPU_W     = 16;
	localparam int COUNT_W   = 8;
	localparam int OUT_IDX_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W    = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_UNIT = 2'd2;

	localparam logic [POS_W-1:0] ORIGIN_RESET = 32'hFFFE_0000;
	localparam logic [CPU_W-1:0] CPU_RESET    = 16'd256;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/core/ghcm_front.sv]
// front end: position to clamped cell index and grid address
module ghcm_front #(
	parameter int GRID_COLS = ghcm_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = ghcm_pkg::GRID_ROWS_DEF,
	parameter int CW = $clog2(GRID_COLS),
	parameter int RW = $clog2(GRID_ROWS),
	parameter int AW = $clog2(GRID_COLS * GRID_ROWS),
	parameter int IW = 1 + RW + CW + AW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [ghcm_pkg::POS_W-1:0]    pos_x,
	input  logic [ghcm_pkg::POS_W-1:0]    pos_y,
	input  logic [ghcm_pkg::POS_W-1:0]    origin_x,
	input  logic [ghcm_pkg::POS_W-1:0]    origin_y,
	input  logic [ghcm_pkg::CPU_W-1:0]    cells_per_unit,
	input  logic                          blocked,
	input  ghcm_pkg::q_status_t           q_status,
	output logic                          push,
	output logic [IW-1:0]                 push_item
);
	localparam int PW = ghcm_pkg::POS_W;
	localparam int MW = ghcm_pkg::POS_W + ghcm_pkg::CPU_W;

	logic          adv;
	logic          v_s1, v_s2, v_s3;
	logic          req_s1, req_s2, req_s3;
	logic [PW:0]   dx_s1, dy_s1;
	logic          negx_s2, negy_s2;
	logic [MW-1:0] px_s2, py_s2;
	logic [CW-1:0] col_s3;
	logic [RW-1:0] row_s3;
	logic [PW-1:0] idx_x, idx_y;
	logic [CW-1:0] col_next;
	logic [RW-1:0] row_next;
	logic [AW-1:0] addr;

	assign adv      = !(v_s3 && q_status.full);
	assign in_stall = blocked || !adv;
	assign push     = v_s3 && !q_status.full;

	// floor of the 16 fraction bit product, clamped into the grid
	assign idx_x = px_s2[MW-1:ghcm_pkg::FRAC_W];
	assign idx_y = py_s2[MW-1:ghcm_pkg::FRAC_W];

	always_comb begin
		if (negx_s2) begin
			col_next = '0;
		end else if (idx_x >= PW'(GRID_COLS)) begin
			col_next = CW'(GRID_COLS - 1);
		end else begin
			col_next = idx_x[CW-1:0];
		end
		if (negy_s2) begin
			row_next = '0;
		end else if (idx_y >= PW'(GRID_ROWS)) begin
			row_next = RW'(GRID_ROWS - 1);
		end else begin
			row_next = idx_y[RW-1:0];
		end
	end

	assign addr      = AW'(AW'(row_s3) * AW'(GRID_COLS)) + AW'(col_s3);
	assign push_item = {req_s3, row_s3, col_s3, addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && !blocked;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1  <= req_type;
			dx_s1   <= {pos_x[PW-1], pos_x} - {origin_x[PW-1], origin_x};
			dy_s1   <= {pos_y[PW-1], pos_y} - {origin_y[PW-1], origin_y};
			req_s2  <= req_s1;
			negx_s2 <= dx_s1[PW];
			negy_s2 <= dy_s1[PW];
			px_s2   <= MW'(dx_s1[PW-1:0]) * MW'(cells_per_unit);
			py_s2   <= MW'(dy_s1[PW-1:0]) * MW'(cells_per_unit);
			req_s3  <= req_s2;
			col_s3  <= col_next;
			row_s3  <= row_next;
		end
	end

endmodule

[rtl/core/ghcm_queue.sv]
// short queue of classified cell operations between front and back
module ghcm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ghcm_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    push_item,
	input  logic                pop,
	output logic [WIDTH-1:0]    head,
	output ghcm_pkg::q_status_t q_status
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;

	assign head           = entries_q[rd_ptr_q];
	assign q_status.full  = (count_q == (PW+1)'(DEPTH));
	assign q_status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/core/ghcm_back.sv]
// back end: count memory, read-modify-write with forwarding, result register
module ghcm_back #(
	parameter int GRID_COLS = ghcm_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = ghcm_pkg::GRID_ROWS_DEF,
	parameter int CW = $clog2(GRID_COLS),
	parameter int RW = $clog2(GRID_ROWS),
	parameter int AW = $clog2(GRID_COLS * GRID_ROWS),
	parameter int IW = 1 + RW + CW + AW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [IW-1:0]                     head,
	input  ghcm_pkg::q_status_t               q_status,
	output logic                              pop,
	output logic                              clearing,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ghcm_pkg::COUNT_W-1:0]      cell_count,
	output logic [ghcm_pkg::OUT_IDX_W-1:0]    cell_col,
	output logic [ghcm_pkg::OUT_IDX_W-1:0]    cell_row
);
	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int NW    = ghcm_pkg::COUNT_W;
	localparam int OW    = ghcm_pkg::OUT_IDX_W;

	logic [NW-1:0] grid_mem [DEPTH];

	logic          clearing_q;
	logic [AW-1:0] clr_q;
	logic          b_vld_s1;
	logic [IW-1:0] b_item_s1;
	logic [NW-1:0] rd_data_s1;
	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [NW-1:0] wr_data_q;
	logic          out_valid_q;
	logic [NW-1:0] cell_count_q;
	logic [OW-1:0] cell_col_q, cell_row_q;

	logic          b_req;
	logic [RW-1:0] b_row;
	logic [CW-1:0] b_col;
	logic [AW-1:0] b_addr;
	logic [AW-1:0] head_addr;
	logic          b_blocked, b_moves, b_record;
	logic [NW-1:0] cur_count, next_count;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [NW-1:0] mem_wdata;

	assign {b_req, b_row, b_col, b_addr} = b_item_s1;
	assign head_addr = head[AW-1:0];

	assign b_blocked = b_vld_s1 && (b_req == ghcm_pkg::REQ_QUERY) && out_valid_q && out_stall;
	assign b_moves   = b_vld_s1 && !b_blocked;
	assign b_record  = b_vld_s1 && (b_req == ghcm_pkg::REQ_RECORD);
	assign pop       = !clearing_q && !q_status.empty && !b_blocked;

	// latest write wins over the registered read of the same cell
	assign cur_count  = (wr_vld_q && wr_addr_q == b_addr) ? wr_data_q : rd_data_s1;
	assign next_count = (cur_count == ghcm_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

	assign mem_we    = clearing_q || b_record;
	assign mem_waddr = clearing_q ? clr_q : b_addr;
	assign mem_wdata = clearing_q ? '0 : next_count;

	assign clearing   = clearing_q;
	assign out_valid  = out_valid_q;
	assign cell_count = cell_count_q;
	assign cell_col   = cell_col_q;
	assign cell_row   = cell_row_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rd_data_s1 <= grid_mem[head_addr];
			b_item_s1  <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			b_vld_s1    <= 1'b0;
			wr_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_q == AW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_q <= clr_q + 1'b1;
				end
			end
			if (pop) begin
				b_vld_s1 <= 1'b1;
			end else if (b_moves) begin
				b_vld_s1 <= 1'b0;
			end
			if (b_record) begin
				wr_vld_q <= 1'b1;
			end
			if (b_moves && b_req == ghcm_pkg::REQ_QUERY) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b_record) begin
			wr_addr_q <= b_addr;
			wr_data_q <= next_count;
		end
		if (b_moves && b_req == ghcm_pkg::REQ_QUERY) begin
			cell_count_q <= cur_count;
			cell_col_q   <= OW'(b_col);
			cell_row_q   <= OW'(b_row);
		end
	end

endmodule

[rtl/core/grid_hit_count_map_core.sv]
// top level of the grid hit count map: config registers, front, queue, back
// throughput: one item per cycle unless a stalled result or the clearing pass holds it,
// kept up by the pipelined read-modify-write with forwarding
// records give no result; queries leave through an output register that decouples out_stall
// reset: async, active low; registers take their reset values, then a clearing pass writes
// zero to every one of the GRID_COLS*GRID_ROWS cells, with in_stall high
module grid_hit_count_map_core #(
	parameter int GRID_COLS = ghcm_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = ghcm_pkg::GRID_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [ghcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ghcm_pkg::POS_W-1:0]        cfg_wdata,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [ghcm_pkg::POS_W-1:0]        pos_x,
	input  logic [ghcm_pkg::POS_W-1:0]        pos_y,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ghcm_pkg::COUNT_W-1:0]      cell_count,
	output logic [ghcm_pkg::OUT_IDX_W-1:0]    cell_col,
	output logic [ghcm_pkg::OUT_IDX_W-1:0]    cell_row
);
	localparam int CW = $clog2(GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int AW = $clog2(GRID_COLS * GRID_ROWS);
	// queue entry: request type, row, column, flat grid address
	localparam int IW = 1 + RW + CW + AW;

	logic [ghcm_pkg::POS_W-1:0] origin_x_q, origin_y_q;
	logic [ghcm_pkg::CPU_W-1:0] cells_per_unit_q;

	logic                clearing;
	logic                push, pop;
	logic [IW-1:0]       push_item, head;
	ghcm_pkg::q_status_t q_status;

	// config registers, to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q       <= ghcm_pkg::ORIGIN_RESET;
			origin_y_q       <= ghcm_pkg::ORIGIN_RESET;
			cells_per_unit_q <= ghcm_pkg::CPU_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ghcm_pkg::CFG_ORIGIN_X:       origin_x_q <= cfg_wdata;
				ghcm_pkg::CFG_ORIGIN_Y:       origin_y_q <= cfg_wdata;
				ghcm_pkg::CFG_CELLS_PER_UNIT: cells_per_unit_q <= cfg_wdata[ghcm_pkg::CPU_W-1:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// front: subtract origin, scale, floor, clamp, form the grid address
	ghcm_front #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS),
		.CW        (CW),
		.RW        (RW),
		.AW        (AW),
		.IW        (IW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.origin_x       (origin_x_q),
		.origin_y       (origin_y_q),
		.cells_per_unit (cells_per_unit_q),
		.blocked        (clearing),
		.q_status       (q_status),
		.push           (push),
		.push_item      (push_item)
	);

	// decoupling queue: front keeps running during a result stall until the queue is full
	ghcm_queue #(
		.WIDTH (IW),
		.DEPTH (ghcm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	// back: count memory with saturating update and query results
	ghcm_back #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS),
		.CW        (CW),
		.RW        (RW),
		.AW        (AW),
		.IW        (IW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_count (cell_count),
		.cell_col   (cell_col),
		.cell_row   (cell_row)
	);

	// no result can appear while the memory is still being cleared
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid)
		else $error("result valid during clearing pass");

	// nothing enters the queue before the clearing pass is done
	a_queue_empty_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> q_status.empty)
		else $error("queue holds an item during clearing pass");

	// the back end only takes an item that is actually queued
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// an accepted request needs a finished clearing pass
	a_accept_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !clearing)
		else $error("request accepted during clearing pass");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench of grid_hit_count_map_core with its own hit grid predictor
module tb_top;

	localparam int COLS = ghcm_pkg::GRID_COLS_DEF;
	localparam int ROWS = ghcm_pkg::GRID_ROWS_DEF;
	localparam int PW = ghcm_pkg::POS_W;
	// index 3 has no register behind it, writes there must change nothing
	localparam logic [ghcm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int QUIET_CYCLES = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_PHASES = 6;
	// several times the clearing pass after reset plus a wide margin for the stalled traffic
	localparam longint LIMIT_CYCLES = longint'(COLS) * ROWS * 3 + 400000;

	typedef struct packed {
		logic                   req;
		logic [PW-1:0]          x;
		logic [PW-1:0]          y;
	} grid_req_t;

	typedef struct packed {
		logic [ghcm_pkg::COUNT_W-1:0]   count;
		logic [ghcm_pkg::OUT_IDX_W-1:0] col;
		logic [ghcm_pkg::OUT_IDX_W-1:0] row;
	} cell_answer_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [ghcm_pkg::CFG_IDX_W-1:0]   cfg_index = ghcm_pkg::CFG_ORIGIN_X;
	logic [PW-1:0]                    cfg_wdata = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             req_type = ghcm_pkg::REQ_RECORD;
	logic [PW-1:0]                    pos_x = '0;
	logic [PW-1:0]                    pos_y = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [ghcm_pkg::COUNT_W-1:0]     cell_count;
	logic [ghcm_pkg::OUT_IDX_W-1:0]   cell_col;
	logic [ghcm_pkg::OUT_IDX_W-1:0]   cell_row;

	// predictor copy of the registers and the count grid
	logic [PW-1:0]                    org_x_m = ghcm_pkg::ORIGIN_RESET;
	logic [PW-1:0]                    org_y_m = ghcm_pkg::ORIGIN_RESET;
	logic [ghcm_pkg::CPU_W-1:0]       cpu_m = ghcm_pkg::CPU_RESET;
	bit [ghcm_pkg::COUNT_W-1:0]       hits_m [COLS*ROWS];

	grid_req_t              req_backlog[$];
	cell_answer_t           query_answers[$];
	grid_req_t              next_req;
	cell_answer_t           got_answer;
	logic                   in_taken = 1'b0;

	// idling controls written by the stimulus; hold_served and hold_left by the receiver
	int                     send_gap_pct = 0;
	int                     recv_stall_pct = 0;
	int                     hold_asks = 0;
	int                     hold_served = 0;
	int                     hold_left = 0;

	int                     mismatches = 0;
	int                     n_records = 0;
	int                     n_queries = 0;
	int                     n_full_hits = 0;
	int                     n_clamped = 0;
	int                     n_settings = 0;
	longint                 cycle_count;

	grid_hit_count_map_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_count (cell_count),
		.cell_col   (cell_col),
		.cell_row   (cell_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one axis: offset from origin, scale by cells per unit, floor, clamp
	function automatic int unsigned axis_index(logic signed [PW-1:0] pos,
			logic signed [PW-1:0] org, int unsigned size);
		longint delta;
		longint scaled;
		delta = longint'(pos) - longint'(org);
		if (delta < 0) begin
			n_clamped++;
			return 0;
		end
		scaled = (delta * longint'(cpu_m)) >>> ghcm_pkg::FRAC_W;
		if (scaled >= longint'(size)) begin
			n_clamped++;
			return size - 1;
		end
		return 32'(scaled);
	endfunction

	// update the grid for a record, or queue the answer a query must get
	task automatic apply_request(grid_req_t r);
		int unsigned col;
		int unsigned row;
		int unsigned at;
		cell_answer_t ans;
		col = axis_index(r.x, org_x_m, COLS);
		row = axis_index(r.y, org_y_m, ROWS);
		at = row * COLS + col;
		if (r.req == ghcm_pkg::REQ_RECORD) begin
			n_records++;
			if (hits_m[at] == ghcm_pkg::COUNT_MAX)
				n_full_hits++;
			else
				hits_m[at] = hits_m[at] + 1'b1;
		end else begin
			n_queries++;
			ans.count = hits_m[at];
			ans.col = col[ghcm_pkg::OUT_IDX_W-1:0];
			ans.row = row[ghcm_pkg::OUT_IDX_W-1:0];
			query_answers.push_back(ans);
		end
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// request driver: a new transaction only once the previous one was taken
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				next_req = req_backlog.pop_front();
				in_valid <= 1'b1;
				req_type <= next_req.req;
				pos_x <= next_req.x;
				pos_y <= next_req.y;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// request monitor: every accepted transaction goes through the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			apply_request({req_type, pos_x, pos_y});
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
	end

	// result receiver: random stall, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// result monitor: compare each accepted result with the oldest answer due
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (query_answers.size() == 0) begin
				$error("result with no query pending: count %0d col %0d row %0d",
					cell_count, cell_col, cell_row);
				mismatches++;
			end else begin
				got_answer = query_answers.pop_front();
				check_field("cell_count", 32'(got_answer.count), 32'(cell_count));
				check_field("cell_col", 32'(got_answer.col), 32'(cell_col));
				check_field("cell_row", 32'(got_answer.row), 32'(cell_row));
			end
		end
	end

	task automatic write_reg(logic [ghcm_pkg::CFG_IDX_W-1:0] idx, logic [PW-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			ghcm_pkg::CFG_ORIGIN_X:       org_x_m = data;
			ghcm_pkg::CFG_ORIGIN_Y:       org_y_m = data;
			ghcm_pkg::CFG_CELLS_PER_UNIT: cpu_m = data[ghcm_pkg::CPU_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_req(logic req, logic [PW-1:0] x, logic [PW-1:0] y);
		grid_req_t r;
		r.req = req;
		r.x = x;
		r.y = y;
		req_backlog.push_back(r);
	endtask

	// mostly positions in a few cells near the origin or the far edge, so cells collide
	function automatic logic [PW-1:0] pick_pos(logic [PW-1:0] org);
		int unsigned roll;
		longint span;
		longint far_off;
		span = (cpu_m == 0) ? 4096 : (6 * 65536) / longint'(cpu_m) + 1;
		far_off = (cpu_m == 0) ? 0 : (1022 * 65536) / longint'(cpu_m);
		roll = $urandom_range(99);
		if (roll < 60)
			return org + $urandom_range(0, 32'(span)) - 32'd64;
		if (roll < 72)
			return org + 32'(far_off) + $urandom_range(0, 32'(span));
		if (roll < 88)
			return $urandom;
		case ($urandom_range(5))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			4:       return org;
			default: return org - 32'd1;
		endcase
	endfunction

	// the block is idle once nothing is queued, offered or owed, and records have settled
	task automatic wait_idle();
		while (req_backlog.size() != 0 || in_valid || query_answers.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase;
		int n_items;
		int query_pct;
		grid_req_t r;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			n_items = 250;
			query_pct = 40;
			n_settings++;
			case (phase)
				0: begin
					// reset settings: origin -512.0, one cell per unit
					send_gap_pct = 24;
					recv_stall_pct = 62;
					n_items = 285;
					push_req(ghcm_pkg::REQ_RECORD, ghcm_pkg::ORIGIN_RESET,
						ghcm_pkg::ORIGIN_RESET);
					// below the origin clamps to the corner cell
					push_req(ghcm_pkg::REQ_RECORD, 32'h8000_0000, 32'h8000_0000);
					push_req(ghcm_pkg::REQ_QUERY, ghcm_pkg::ORIGIN_RESET,
						ghcm_pkg::ORIGIN_RESET);
					// beyond the grid clamps to the last cell
					push_req(ghcm_pkg::REQ_RECORD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
					push_req(ghcm_pkg::REQ_QUERY, 32'd131071, 32'd130816);
					push_req(ghcm_pkg::REQ_QUERY, 32'd130815, 32'd130816);
					push_req(ghcm_pkg::REQ_QUERY, ghcm_pkg::ORIGIN_RESET - 32'd1,
						32'h7FFF_FFFF);
					push_req(ghcm_pkg::REQ_RECORD, 32'd0, 32'd0);
					push_req(ghcm_pkg::REQ_RECORD, 32'd255, 32'd255);
					push_req(ghcm_pkg::REQ_QUERY, 32'd0, 32'd0);
					push_req(ghcm_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'd256);
					push_req(ghcm_pkg::REQ_RECORD, 32'hFFFF_FFFF, 32'd0);
					push_req(ghcm_pkg::REQ_QUERY, 32'hFFFF_FF00, 32'd0);
					push_req(ghcm_pkg::REQ_RECORD, 32'h7FFF_FFFF, 32'h8000_0000);
					push_req(ghcm_pkg::REQ_QUERY, 32'h5555_5555, 32'hAAAA_AAAA);
					push_req(ghcm_pkg::REQ_QUERY, 32'hAAAA_AAAA, 32'h5555_5555);
				end
				1: begin
					// extreme origins and finest cells; receiver holds off to fill the block
					write_reg(ghcm_pkg::CFG_ORIGIN_X, 32'h8000_0000);
					write_reg(ghcm_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF);
					write_reg(ghcm_pkg::CFG_CELLS_PER_UNIT, 32'h5A5A_FFFF);
					write_reg(CFG_SPARE, $urandom);
					query_pct = 60;
					hold_asks++;
				end
				2: begin
					send_gap_pct = 62;
					recv_stall_pct = 24;
					write_reg(ghcm_pkg::CFG_ORIGIN_X, $urandom);
					write_reg(ghcm_pkg::CFG_ORIGIN_Y, $urandom);
					write_reg(ghcm_pkg::CFG_CELLS_PER_UNIT,
						{16'($urandom_range(65535)), 16'd1});
				end
				3: begin
					// zero cells per unit folds every position onto the corner cell,
					// enough records there to saturate it
					write_reg(ghcm_pkg::CFG_ORIGIN_X, $urandom);
					write_reg(ghcm_pkg::CFG_ORIGIN_Y, $urandom);
					write_reg(ghcm_pkg::CFG_CELLS_PER_UNIT,
						{16'($urandom_range(65535)), 16'd0});
					n_items = 350;
					query_pct = 20;
				end
				4: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
					write_reg(ghcm_pkg::CFG_ORIGIN_X, '0);
					write_reg(ghcm_pkg::CFG_ORIGIN_Y, '0);
					write_reg(ghcm_pkg::CFG_CELLS_PER_UNIT, $urandom_range(65535, 1));
				end
				default: begin
					write_reg(ghcm_pkg::CFG_ORIGIN_X, $urandom);
					write_reg(ghcm_pkg::CFG_ORIGIN_Y, $urandom);
					write_reg(ghcm_pkg::CFG_CELLS_PER_UNIT, $urandom);
					write_reg(CFG_SPARE, $urandom);
				end
			endcase
			repeat (n_items) begin
				r.req = ($urandom_range(99) < query_pct) ? ghcm_pkg::REQ_QUERY :
					ghcm_pkg::REQ_RECORD;
				r.x = pick_pos(org_x_m);
				r.y = pick_pos(org_y_m);
				req_backlog.push_back(r);
			end
			// sender pauses here until every answer of the phase is in
			wait_idle();
		end
		$display("covered %0d records and %0d queries over %0d register settings",
			n_records, n_queries, n_settings);
		$display("%0d records hit full cells, %0d coordinates clamped into the grid",
			n_full_hits, n_clamped);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d answers outstanding",
			cycle_count, query_answers.size());
		$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/ghcm_pkg.sv
rtl/core/ghcm_front.sv
rtl/core/ghcm_queue.sv
rtl/core/ghcm_back.sv
rtl/core/grid_hit_count_map_core.sv
test/tb_top.sv
